### rtl/core/predictor_byte_compressor_defines.svh
// Assertion macros shared by the compressor RTL.
`ifndef PREDICTOR_BYTE_COMPRESSOR_DEFINES_SVH
`define PREDICTOR_BYTE_COMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PBC_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PBC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pbc: next-cycle check failed");

`endif

### rtl/core/pbc_pkg.sv
// Shared types and constants of the predictor byte compressor.
package pbc_pkg;

  localparam int unsigned GROUP_LEN = 8;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } pbc_state_t;

  // One classified byte travelling from the predictor to the packer.
  typedef struct packed {
    logic [7:0] data;
    logic       miss;
    logic       eos;
  } pbc_rec_t;

endpackage

### rtl/core/pbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/pbc_front.sv
// Predictor front end: table clearing, hash tracking, hit/miss classification.
`include "predictor_byte_compressor_defines.svh"

module pbc_front #(
  parameter int unsigned HASH_BITS = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             end_of_stream,
  output logic             rec_valid,
  input  logic             rec_ready,
  output pbc_pkg::pbc_rec_t rec
);

  localparam logic [HASH_BITS-1:0] ADDR_LAST = {HASH_BITS{1'b1}};

  pbc_pkg::pbc_state_t state;
  pbc_pkg::pbc_state_t state_next;

  logic [HASH_BITS-1:0] clr_addr;
  logic [HASH_BITS-1:0] hash;
  logic                 clearing;

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_eos;
  logic [HASH_BITS-1:0] s1_idx;
  logic                 s1_fwd;
  logic [7:0]           s1_fwd_byte;

  logic                 accept;
  logic                 push;
  logic [7:0]           rd_data;
  logic [7:0]           pred;
  logic                 wr_en;
  logic [HASH_BITS-1:0] wr_addr;
  logic [7:0]           wr_data;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pbc_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_LAST) begin
          state_next = pbc_pkg::ST_RUN;
        end
      end
      pbc_pkg::ST_RUN: begin
        state_next = pbc_pkg::ST_RUN;
      end
      default: begin
        state_next = pbc_pkg::ST_CLEAR;
      end
    endcase
  end

  // State outputs
  always_comb begin
    case (state)
      pbc_pkg::ST_CLEAR: clearing = 1'b1;
      pbc_pkg::ST_RUN:   clearing = 1'b0;
      default:           clearing = 1'b1;
    endcase
  end

  assign push     = s1_valid && rec_ready;
  assign in_ready = !clearing && (!s1_valid || rec_ready);
  assign accept   = in_valid && in_ready;

  // Take the prediction from the byte written at the same edge as the read
  assign pred = s1_fwd ? s1_fwd_byte : rd_data;

  assign rec_valid = s1_valid;
  assign rec.data  = s1_byte;
  assign rec.miss  = (pred != s1_byte);
  assign rec.eos   = s1_eos;

  assign wr_en   = clearing || push;
  assign wr_addr = clearing ? clr_addr : s1_idx;
  assign wr_data = clearing ? 8'd0 : s1_byte;

  pbc_ram #(
    .WIDTH(8),
    .DEPTH(1 << HASH_BITS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(hash),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pbc_pkg::ST_CLEAR;
      clr_addr <= '0;
      hash     <= '0;
      s1_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        hash     <= HASH_BITS'({hash, 4'b0000}) ^ HASH_BITS'(data_byte);
        s1_valid <= 1'b1;
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte     <= data_byte;
      s1_eos      <= end_of_stream;
      s1_idx      <= hash;
      s1_fwd      <= push && (s1_idx == hash);
      s1_fwd_byte <= s1_byte;
    end
  end

  `PBC_ASSERT_NEXT(a_clear_ends, clk, rst,
                   clearing && (clr_addr == ADDR_LAST), state == pbc_pkg::ST_RUN)
  `PBC_ASSERT_NEXT(a_stage_drains, clk, rst, push && !accept, !s1_valid)

endmodule

### rtl/core/pbc_fifo.sv
// Short queue of classified bytes between the predictor and the packer.
module pbc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  pbc_pkg::pbc_rec_t push_rec,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pbc_pkg::pbc_rec_t pop_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pbc_pkg::pbc_rec_t slots [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_rec    = slots[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PTR_LAST) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_rec;
    end
  end

endmodule

### rtl/core/pbc_pack.sv
// Group packer: gathers flags and literals, then serialises each finished group.
`include "predictor_byte_compressor_defines.svh"

module pbc_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_valid,
  output logic              rec_ready,
  input  pbc_pkg::pbc_rec_t rec,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              is_flags,
  output logic              last_of_run
);

  localparam logic [2:0] POS_LAST = 3'(pbc_pkg::GROUP_LEN - 1);

  // Group being gathered
  logic [2:0] pos;
  logic [7:0] flags;
  logic [3:0] lit_count;
  logic [7:0] lits [pbc_pkg::GROUP_LEN];

  // Finished group being sent
  logic       emit_valid;
  logic [7:0] emit_flags;
  logic [7:0] emit_lits [pbc_pkg::GROUP_LEN];
  logic [3:0] emit_count;
  logic [3:0] emit_idx;

  logic       close;
  logic       bank_free;
  logic       pop;
  logic       out_fire;
  logic       emit_last;
  logic [7:0] flags_next;
  logic [7:0] flags_aligned;
  logic [3:0] count_next;
  logic [7:0] lits_next [pbc_pkg::GROUP_LEN];

  assign emit_last = (emit_idx == emit_count);
  assign out_fire  = emit_valid && out_ready;
  assign bank_free = !emit_valid || (out_fire && emit_last);
  assign close     = rec.eos || (pos == POS_LAST);
  assign pop       = rec_valid && (!close || bank_free);
  assign rec_ready = !close || bank_free;

  assign flags_next    = {flags[6:0], rec.miss};
  // Left-align a short group so its first byte sits in the MSB
  assign flags_aligned = flags_next << (POS_LAST - pos);
  assign count_next    = lit_count + {3'b000, rec.miss};

  always_comb begin
    lits_next = lits;
    if (rec.miss) begin
      lits_next[lit_count[2:0]] = rec.data;
    end
  end

  assign out_valid   = emit_valid;
  assign is_flags    = (emit_idx == 4'd0);
  assign last_of_run = emit_last;
  assign out_byte    = is_flags ? emit_flags : emit_lits[3'(emit_idx - 4'd1)];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      flags      <= '0;
      lit_count  <= '0;
      emit_valid <= 1'b0;
      emit_idx   <= '0;
      emit_count <= '0;
    end else begin
      if (pop) begin
        if (close) begin
          pos       <= '0;
          flags     <= '0;
          lit_count <= '0;
        end else begin
          pos       <= pos + 1'b1;
          flags     <= flags_next;
          lit_count <= count_next;
        end
      end
      if (pop && close) begin
        emit_valid <= 1'b1;
        emit_idx   <= '0;
        emit_count <= count_next;
      end else if (out_fire) begin
        if (emit_last) begin
          emit_valid <= 1'b0;
        end else begin
          emit_idx <= emit_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lits <= lits_next;
    end
    if (pop && close) begin
      emit_flags <= flags_aligned;
      emit_lits  <= lits_next;
    end
  end

  `PBC_ASSERT_NOW(a_idx_in_range, clk, rst, emit_valid, emit_idx <= emit_count)
  `PBC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, lit_count <= {1'b0, pos})
  `PBC_ASSERT_NEXT(a_group_restart, clk, rst, out_fire && emit_last,
                   !emit_valid || (emit_idx == 4'd0))

endmodule

### rtl/core/predictor_byte_compressor.sv
// A group-closing byte crosses the front stage and queue; the packer registers its flag word.
// Throughput: one byte per cycle in; a group leaves as a flag word plus one word per literal.
// Output: one word per cycle while out_ready holds; all-miss or short groups can slow the input.
// Reset: synchronous, active high; the 2^HASH_BITS-entry table is then cleared one entry
// per cycle, with in_ready low until the sweep is done.
// Table read and write share one RAM; a one-deep forward covers back-to-back same-entry accesses.
module predictor_byte_compressor #(
  parameter int unsigned HASH_BITS   = 20,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_flags,
  output logic       last_of_run
);

  // Front to queue
  logic              fq_valid;
  logic              fq_ready;
  pbc_pkg::pbc_rec_t fq_rec;

  // Queue to packer
  logic              qp_valid;
  logic              qp_ready;
  pbc_pkg::pbc_rec_t qp_rec;

  // Predict each word against the hashed table entry and classify hit or miss
  pbc_front #(
    .HASH_BITS(HASH_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .rec_valid    (fq_valid),
    .rec_ready    (fq_ready),
    .rec          (fq_rec)
  );

  // Decouple the predictor from output stalls
  pbc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_rec  (fq_rec),
    .pop_valid (qp_valid),
    .pop_ready (qp_ready),
    .pop_rec   (qp_rec)
  );

  // Gather groups of eight and send flag word followed by literals
  pbc_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (qp_valid),
    .rec_ready  (qp_ready),
    .rec        (qp_rec),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_flags   (is_flags),
    .last_of_run(last_of_run)
  );

endmodule

### bench/predictor_byte_compressor_checker.sv
// Channel monitor, compression predictor and word comparator for the byte compressor.
`timescale 1ns / 100ps

module predictor_byte_compressor_checker #(
  parameter int unsigned HASH_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       is_flags,
  input  logic       last_of_run,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [7:0] value;
    logic       flag;
    logic       last;
  } comp_word_t;

  // Predictor state: byte table, rolling context and the group being built.
  bit [7:0]           byte_table [0:(1 << HASH_BITS) - 1];
  bit [HASH_BITS-1:0] ctx_hash = '0;
  bit [7:0]           miss_bits = '0;
  int unsigned        group_fill = 0;
  bit [7:0]           literal_q [0:pbc_pkg::GROUP_LEN-1];
  int unsigned        literal_n = 0;

  comp_word_t expected_words [$];

  int fail_n = 0;
  int waiting_n = 0;

  assign errors  = fail_n;
  assign pending = waiting_n;

  // Classify one byte, update the table and context, queue the group's words once it closes.
  function automatic void predict_byte(input logic [7:0] b, input logic eos);
    bit [HASH_BITS-1:0] idx;
    bit [7:0]           flag_word;
    int unsigned        fill;
    int unsigned        i;
    idx       = ctx_hash;
    miss_bits = miss_bits << 1;
    if (byte_table[idx] != b) begin
      miss_bits[0]         = 1'b1;
      literal_q[literal_n] = b;
      literal_n++;
    end
    byte_table[idx] = b;
    ctx_hash        = (idx << 4) ^ b;
    fill = group_fill + 1;
    if (fill < pbc_pkg::GROUP_LEN && !eos) begin
      group_fill = fill;
      return;
    end
    // Left-align a short group so its first byte owns the MSB.
    flag_word = miss_bits << (pbc_pkg::GROUP_LEN - fill);
    expected_words.push_back('{flag_word, 1'b1, literal_n == 0});
    for (i = 0; i < literal_n; i++)
      expected_words.push_back('{literal_q[i], 1'b0, i + 1 == literal_n});
    miss_bits  = '0;
    group_fill = 0;
    literal_n  = 0;
  endfunction

  // Everything moves on the rising edge only, so the falling edge sees settled values
  // that equal what the next rising edge will take.
  always @(negedge clk) begin : watch
    comp_word_t exp_w;
    if (!rst) begin
      if (in_valid && in_ready)
        predict_byte(data_byte, end_of_stream);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_n++;
          $error("unexpected word: out_byte=%h is_flags=%b last_of_run=%b",
                 out_byte, is_flags, last_of_run);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_byte !== exp_w.value) begin
            fail_n++;
            $error("out_byte: expected %h, got %h", exp_w.value, out_byte);
          end
          if (is_flags !== exp_w.flag) begin
            fail_n++;
            $error("is_flags: expected %b, got %b", exp_w.flag, is_flags);
          end
          if (last_of_run !== exp_w.last) begin
            fail_n++;
            $error("last_of_run: expected %b, got %b", exp_w.last, last_of_run);
          end
        end
      end
      waiting_n = expected_words.size();
    end
  end

endmodule

### bench/predictor_byte_compressor_tb.sv
// Stimulus, reset, watchdog and verdict for the predictor byte compressor.
`timescale 1ns / 100ps

module predictor_byte_compressor_tb;

  localparam int unsigned HASH_BITS    = 20;
  // The table sweep after reset alone keeps the input shut; allow for the whole sweep
  // before calling the run hung.
  localparam int unsigned STALL_LIMIT  = 3_000_000;
  localparam int unsigned PHASE_ITEMS  = 61;

  logic       clk;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic [7:0] data_byte     = 8'h00;
  logic       end_of_stream = 1'b0;
  logic       out_ready     = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        is_flags;
  wire        last_of_run;

  int          errors;
  int          pending;
  int unsigned src_idle     = 24;
  int unsigned snk_idle     = 71;
  int unsigned quiet_cycles = 0;

  predictor_byte_compressor #(
    .HASH_BITS(HASH_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .is_flags     (is_flags),
    .last_of_run  (last_of_run)
  );

  predictor_byte_compressor_checker #(
    .HASH_BITS(HASH_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .is_flags     (is_flags),
    .last_of_run  (last_of_run),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: decide afresh every cycle whether to stall the output channel.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle);
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one input word, called at a rising edge and returning at the edge that takes it.
  // Idle cycles drop valid first; once raised, valid and the payload hold until taken.
  // Readiness is looked at on the falling edge, where nothing is changing.
  task automatic send_word(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Random streams: mostly a short phrase repeated with rare corruptions, so the context
  // recurs and the table starts predicting; the rest is plain noise. Streams close with
  // end_of_stream at random, and a stray marker can land on any byte of a group.
  task automatic send_random(input int unsigned count, input bit close_last);
    int unsigned sent;
    int unsigned plen;
    int unsigned total;
    int unsigned k;
    logic [7:0]  phrase [0:5];
    logic [7:0]  b;
    logic        eos;
    bit          noisy;
    bit          close_stream;
    sent = 0;
    while (sent < count) begin
      noisy = ($urandom_range(99) < 25);
      plen  = $urandom_range(6, 1);
      for (k = 0; k < plen; k++)
        phrase[k] = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      total        = noisy ? $urandom_range(16, 3) : $urandom_range(40, 8);
      close_stream = ($urandom_range(99) < 60);
      for (k = 0; k < total && sent < count; k++) begin
        if (noisy || $urandom_range(99) < 5)
          b = 8'($urandom_range(255));
        else
          b = phrase[k % plen];
        eos = (close_stream && k + 1 == total) || ($urandom_range(99) < 3) ||
              (close_last && sent + 1 == count);
        send_word(b, eos);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int k;
    logic [7:0] spread [0:7];
    spread = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h12, 8'hED};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the first word waits out the table sweep.
    // Zeros against a cleared table at context zero: a group of hits, flag word only.
    repeat (8) send_word(8'h00, 1'b0);
    // Non-zero bytes on fresh entries: a group of misses, flag word plus eight literals.
    for (k = 0; k < 8; k++) send_word(spread[k], 1'b0);
    // Stream end on the first byte of a group: flag in the MSB, low bits clear.
    send_word(8'h3C, 1'b1);
    // Short final group of two, then a new stream on the surviving table and context.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    // Stream end on the eighth byte: one emission, as for a full group.
    for (k = 0; k < 8; k++) send_word(8'hA5, k == 7);

    // Random part in three idling phases; flush the last group at the very end.
    send_random(PHASE_ITEMS, 1'b0);
    src_idle = 71;
    snk_idle = 24;
    send_random(PHASE_ITEMS, 1'b0);
    src_idle = 0;
    snk_idle = 0;
    send_random(PHASE_ITEMS, 1'b1);
    in_valid <= 1'b0;

    // Drain, then linger long enough to catch any stray word.
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pbc_pkg.sv
rtl/core/pbc_ram.sv
rtl/core/pbc_front.sv
rtl/core/pbc_fifo.sv
rtl/core/pbc_pack.sv
rtl/core/predictor_byte_compressor.sv
bench/predictor_byte_compressor_checker.sv
bench/predictor_byte_compressor_tb.sv
